// File: sv/bole_pkg.sv
// bole_pkg: shared types and codes for the bounded ordered list engine
// payload structs, mode and status codes, controller/datapath command and status
// no dependencies
`default_nettype none

package bole_pkg;

  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_INS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APP  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SRCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUMP = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic                    found;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] entry_value;
    logic [POS_W-1:0]        entry_count;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_APP,
    OP_DEL,
    OP_SRCH,
    OP_DUMP,
    OP_EMPTY
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } bole_cmd_t;

  typedef struct packed {
    logic empty;
    logic dump_last;
  } bole_sts_t;

endpackage

`default_nettype wire

// File: sv/bole_ctrl.sv
// bole_ctrl: controller state machine of the list engine
// sequences accept, execute and dump steps; depends on bole_pkg
`default_nettype none

module bole_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          in_mode,
  input  bole_pkg::bole_sts_t sts,
  output logic                busy,
  output bole_pkg::bole_cmd_t cmd
);
  import bole_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  state_t            state_r;
  logic [MODE_W-1:0] mode_r;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_INS;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r <= in_mode;
            case (in_mode) inside
              MODE_INS, MODE_APP, MODE_DEL, MODE_SRCH: state_r <= S_EXEC;
              MODE_DUMP: state_r <= sts.empty ? S_EXEC : S_DUMP;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_EXEC: state_r <= S_IDLE;
        S_DUMP: begin
          if (sts.dump_last) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.capture = start && (state_r == S_IDLE);
    cmd.op      = OP_NONE;
    unique case (state_r)
      S_EXEC: begin
        unique case (mode_r)
          MODE_INS:  cmd.op = OP_INS;
          MODE_APP:  cmd.op = OP_APP;
          MODE_DEL:  cmd.op = OP_DEL;
          MODE_SRCH: cmd.op = OP_SRCH;
          MODE_DUMP: cmd.op = OP_EMPTY;
          default:   cmd.op = OP_NONE;
        endcase
      end
      S_DUMP:  cmd.op = OP_DUMP;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bole_dp.sv
// bole_dp: datapath of the list engine, a row of shifting cells with parallel compare
// holds entries, occupancy, match vector and the result register; depends on bole_pkg
`default_nettype none

module bole_dp #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bole_pkg::bole_cmd_t  cmd,
  input  bole_pkg::in_item_t   in_item,
  output bole_pkg::bole_sts_t  sts,
  output logic                 out_valid,
  output bole_pkg::out_item_t  out_item
);
  import bole_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [DATA_WIDTH-1:0] cell_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [CW-1:0]         occ_r;
  logic [CW-1:0]         occ_nxt;
  logic [CW-1:0]         dcnt_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [DATA_WIDTH-1:0] cap_key;
  logic [CAPACITY-1:0]   match_r;
  logic [CAPACITY-1:0]   shift_m;
  logic                  full;
  logic                  any_hit;
  logic [IW-1:0]         hit_idx;
  logic                  out_valid_r;
  out_item_t             out_r;
  out_item_t             out_nxt;

  function automatic logic [IW-1:0] first_one(input logic [CAPACITY-1:0] m);
    logic [IW-1:0] idx;
    idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (m[k]) idx = IW'(k);
    end
    return idx;
  endfunction

  assign cap_key       = DATA_WIDTH'($unsigned(in_item.value));
  assign full          = (occ_r == CW'(CAPACITY));
  assign any_hit       = |match_r;
  assign hit_idx       = first_one(match_r);
  assign sts.empty     = (occ_r == '0);
  assign sts.dump_last = ((dcnt_r + CW'(1)) == occ_r);

  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int k = 0; k < CAPACITY; k++) begin
      acc        = acc | match_r[k];
      shift_m[k] = acc;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_v;
    logic [DATA_WIDTH-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = key_r;
    end else begin : g_mid
      assign prev_v = cell_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_v = cell_r[0];
    end else begin : g_body
      assign next_v = cell_r[i+1];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      case (cmd.op) inside
        OP_INS: begin
          if (!full) cell_nxt[i] = prev_v;
        end
        OP_APP: begin
          if (!full && (CW'(i) == occ_r)) cell_nxt[i] = key_r;
        end
        OP_DEL: begin
          if (shift_m[i]) cell_nxt[i] = next_v;
        end
        OP_DUMP: begin
          cell_nxt[i] = (CW'(i) == (occ_r - CW'(1))) ? cell_r[0] : next_v;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    occ_nxt      = occ_r;
    out_nxt      = '0;
    out_nxt.last = 1'b1;
    case (cmd.op) inside
      OP_INS, OP_APP: begin
        if (full) out_nxt.status = ST_FULL;
        else      occ_nxt        = occ_r + CW'(1);
      end
      OP_DEL, OP_SRCH: begin
        if (any_hit) begin
          out_nxt.found    = 1'b1;
          out_nxt.position = POS_W'(CW'(hit_idx) + CW'(1));
          if (cmd.op == OP_DEL) occ_nxt = occ_r - CW'(1);
        end else begin
          out_nxt.status = ST_NOTFOUND;
        end
      end
      OP_DUMP: begin
        out_nxt.position    = POS_W'(dcnt_r + CW'(1));
        out_nxt.entry_value = VAL_W'(cell_r[0]);
        out_nxt.last        = sts.dump_last;
      end
      OP_EMPTY: out_nxt.status = ST_EMPTY;
      default: ;
    endcase
    out_nxt.entry_count = POS_W'(occ_nxt);
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (cmd.capture) begin
      key_r <= cap_key;
      for (int k = 0; k < CAPACITY; k++) begin
        match_r[k] <= (cell_r[k] == cap_key) && (CW'(k) < occ_r);
      end
    end
    if (cmd.op != OP_NONE) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= (cmd.op != OP_NONE);
      if (cmd.capture)            dcnt_r <= '0;
      else if (cmd.op == OP_DUMP) dcnt_r <= dcnt_r + CW'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// File: sv/bounded_ordered_list_engine.sv
// bounded_ordered_list_engine: top level of the ordered list engine
// joins controller bole_ctrl and datapath bole_dp; depends on bole_pkg
//
//   channel  ports                      handshake
//   input    in_item                    transfer when start && !busy
//   result   out_valid, out_item        one-cycle strobe, always taken
//
// insert, append, delete and search first capture the key and register the parallel
// compare of all cells, then shift the cells and load the result register. dump
// captures first, then gives out the entries, one entry per cycle from the rotating
// cell row. busy is low again when the last result shows.
// the receiver never stalls; every result strobe is a transfer
// reset clears occupancy and control only; entries hold no reset value.
`default_nettype none

module bounded_ordered_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bole_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bole_pkg::out_item_t out_item
);
  import bole_pkg::*;

  bole_cmd_t cmd;
  bole_sts_t sts;

  bole_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_item.mode),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  bole_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: sv/bole_chk.sv
// bole_chk: port-level checker for the list engine, bound to the top level
// depends on bole_pkg and bounded_ordered_list_engine
`default_nettype none

module bole_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input bole_pkg::in_item_t  in_item,
  input logic                out_valid,
  input bole_pkg::out_item_t out_item
);
  import bole_pkg::*;

  logic acc;
  assign acc = start && !busy;

  a_single_op_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_item.mode == MODE_INS || in_item.mode == MODE_APP ||
            in_item.mode == MODE_DEL || in_item.mode == MODE_SRCH)
    |-> ##2 (out_valid && out_item.last))
    else $error("update or search result missing");

  a_bad_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_item.mode != MODE_INS && in_item.mode != MODE_APP &&
            in_item.mode != MODE_DEL && in_item.mode != MODE_SRCH &&
            in_item.mode != MODE_DUMP)
    |=> !busy)
    else $error("unknown mode occupied the engine");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("engine still busy after final result");

  a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("dump stream broke off");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.last)
    else $error("error result not marked last");

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (.*);

`default_nettype wire

// File: sim/bole_checker.sv
// bole_checker: watches the command and result channels of the ordered list engine,
// keeps its own copy of the list, predicts every result and compares it field by field
// depends on bole_pkg
`default_nettype none

module bole_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  bole_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  bole_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bole_pkg::*;

  logic signed [VAL_W-1:0] list_model[$];
  out_item_t               expected_results[$];
  int                      error_total = 0;

  function automatic out_item_t make_result(logic [STAT_W-1:0] status, logic found,
                                            int position, logic signed [VAL_W-1:0] value,
                                            logic last);
    out_item_t r;
    r.status      = status;
    r.found       = found;
    r.position    = POS_W'(position);
    r.entry_value = value;
    r.entry_count = POS_W'(list_model.size());
    r.last        = last;
    return r;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("status=%0d found=%0d position=%0d value=%0d count=%0d last=%0d",
                     r.status, r.found, r.position, r.entry_value, r.entry_count, r.last);
  endfunction

  task automatic report_mismatch(string msg);
    error_total++;
    $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  task automatic predict_list_op(in_item_t it);
    int hit;
    hit = -1;
    for (int i = 0; i < list_model.size(); i++) begin
      if (hit < 0 && list_model[i] == it.value) begin
        hit = i;
      end
    end
    case (it.mode) inside
      MODE_INS, MODE_APP: begin
        if (list_model.size() >= CAPACITY) begin
          expected_results.push_back(make_result(ST_FULL, 1'b0, 0, '0, 1'b1));
        end else begin
          if (it.mode == MODE_INS) begin
            list_model.push_front(it.value);
          end else begin
            list_model.push_back(it.value);
          end
          expected_results.push_back(make_result(ST_OK, 1'b0, 0, '0, 1'b1));
        end
      end
      MODE_DEL, MODE_SRCH: begin
        if (hit < 0) begin
          expected_results.push_back(make_result(ST_NOTFOUND, 1'b0, 0, '0, 1'b1));
        end else begin
          if (it.mode == MODE_DEL) begin
            list_model.delete(hit);
          end
          expected_results.push_back(make_result(ST_OK, 1'b1, hit + 1, '0, 1'b1));
        end
      end
      MODE_DUMP: begin
        if (list_model.size() == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, 1'b0, 0, '0, 1'b1));
        end else begin
          for (int i = 0; i < list_model.size(); i++) begin
            expected_results.push_back(make_result(ST_OK, 1'b0, i + 1, list_model[i],
                                                   i == list_model.size() - 1));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    string     bad;
    if (expected_results.size() == 0) begin
      report_mismatch({"result with nothing expected: ", show(got)});
      return;
    end
    want = expected_results.pop_front();
    bad  = "";
    if (got.status !== want.status) bad = {bad, " status"};
    if (got.found !== want.found) bad = {bad, " found"};
    if (got.position !== want.position) bad = {bad, " position"};
    if (got.entry_value !== want.entry_value) bad = {bad, " entry_value"};
    if (got.entry_count !== want.entry_count) bad = {bad, " entry_count"};
    if (got.last !== want.last) bad = {bad, " last"};
    if (bad != "") begin
      report_mismatch({"wrong", bad, ": got ", show(got), " / want ", show(want)});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      list_model.delete();
      expected_results.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        check_result(out_item);
      end
      if (start && !busy) begin
        predict_list_op(in_item);
      end
    end
    pending    <= expected_results.size();
    fail_count <= error_total;
  end

endmodule

`default_nettype wire

// File: sim/bounded_ordered_list_engine_tb.sv
// bounded_ordered_list_engine_tb: drives directed and random list commands into the engine
// with random gaps; bole_checker predicts and compares, this module gives the verdict
// depends on bole_pkg, bounded_ordered_list_engine and bole_checker
`default_nettype none

module bounded_ordered_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bole_pkg::*;

  localparam int CAPACITY = 16;
  localparam int BLOCK    = 55;
  localparam int BLOCKS   = 6;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  int                      gap_max = 0;
  logic signed [VAL_W-1:0] value_pool[8];
  logic signed [VAL_W-1:0] recent_keys[$];

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bounded_ordered_list_engine #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(VAL_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  bole_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  task automatic send_command(logic [MODE_W-1:0] mode, logic signed [VAL_W-1:0] value);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{mode: mode, value: value};
    do @(posedge clk); while (busy !== 1'b0);
    if (mode == MODE_INS || mode == MODE_APP) begin
      recent_keys.push_back(value);
      if (recent_keys.size() > 2 * CAPACITY) begin
        void'(recent_keys.pop_front());
      end
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_insert_value();
    if ($urandom_range(1, 0) == 0) begin
      return value_pool[$urandom_range(7, 0)];
    end
    return $urandom;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_key();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70 && recent_keys.size() > 0) begin
      return recent_keys[$urandom_range(recent_keys.size() - 1, 0)];
    end
    if (r < 85) begin
      return value_pool[$urandom_range(7, 0)];
    end
    return $urandom;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(bit grow);
    int r;
    r = $urandom_range(99, 0);
    if (r < 3) begin
      return MODE_W'($urandom_range(2 ** MODE_W - 1, MODE_DUMP + 1));
    end
    if (grow) begin
      if (r < 40) return MODE_INS;
      if (r < 75) return MODE_APP;
      if (r < 87) return MODE_DEL;
      if (r < 95) return MODE_SRCH;
      return MODE_DUMP;
    end
    if (r < 13) return MODE_INS;
    if (r < 23) return MODE_APP;
    if (r < 68) return MODE_DEL;
    if (r < 85) return MODE_SRCH;
    return MODE_DUMP;
  endfunction

  initial begin
    logic [MODE_W-1:0] mode;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (int i = 4; i < 8; i++) begin
      value_pool[i] = $urandom;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, then extremes, duplicates, hits at front, middle and back, misses
    gap_max = 2;
    send_command(MODE_DUMP, '0);
    send_command(MODE_SRCH, '0);
    send_command(MODE_DEL, 32'sd5);
    send_command(MODE_INS, VAL_MIN);
    send_command(MODE_APP, VAL_MAX);
    send_command(MODE_INS, '0);
    send_command(MODE_APP, '1);
    send_command(MODE_INS, VAL_MIN);
    send_command(MODE_SRCH, VAL_MIN);
    send_command(MODE_SRCH, VAL_MAX);
    send_command(MODE_SRCH, '1);
    send_command(MODE_SRCH, 32'sd12345);
    send_command(MODE_DEL, 32'sd12345);
    send_command(MODE_DUMP, '0);
    send_command(MODE_DEL, VAL_MIN);
    send_command(MODE_DEL, '1);
    send_command(MODE_DEL, '0);
    send_command(MODE_DUMP, '0);
    for (int m = MODE_DUMP + 1; m < 2 ** MODE_W; m++) begin
      send_command(MODE_W'(m), $urandom);
    end
    send_command(MODE_DUMP, '0);

    // alternate fill and drain phases so the list goes full and empty repeatedly
    for (int b = 0; b < BLOCKS; b++) begin
      gap_max = ($urandom_range(2, 0) == 0) ? 0 : 8;
      for (int n = 0; n < BLOCK; n++) begin
        mode = pick_mode(b % 2 == 0);
        if (mode == MODE_INS || mode == MODE_APP) begin
          send_command(mode, pick_insert_value());
        end else begin
          send_command(mode, pick_key());
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("timeout with %0d results outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
